// ===== src/key_matrix_debounce_deghost_defines.svh =====
// Assertion macros shared by the key matrix debounce RTL.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef KEY_MATRIX_DEBOUNCE_DEGHOST_DEFINES_SVH
`define KEY_MATRIX_DEBOUNCE_DEGHOST_DEFINES_SVH

// Checks a consequent in the same cycle as its antecedent.
`define KMDD_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks a consequent in the cycle after its antecedent.
`define KMDD_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/kmdd_pkg.sv =====
// Package for the key matrix debounce and ghost detection block.
// Holds the default geometry, the stream field widths and the result item type.
package kmdd_pkg;

	localparam int ROWS_DEF    = 8;
	localparam int COLS_DEF    = 16;
	localparam int SAMPLES_DEF = 5;

	localparam int COL_W   = 4;
	localparam int PIN_W   = 8;
	localparam int TDATA_W = 16;

	typedef struct packed {
		logic             send_report;
		logic             ghost_block;
		logic             sweep_changed;
		logic             sweep_done;
		logic             column_changed;
		logic [PIN_W-1:0] pressed_rows;
		logic [COL_W-1:0] column_out;
	} kmdd_result_t;

endpackage

// ===== src/key_matrix_debounce_deghost.sv =====
// Top level of the key matrix debounce and ghost detection block.
// Depends on kmdd_pkg and on the assertion macros in key_matrix_debounce_deghost_defines.svh.
//
// The slave stream carries one scanned column per item: the column index and the raw
// active-low row pin levels. Every key of that column shifts its sample into a history
// and flips its debounced state when the history is uniform and disagrees with it.
// The master stream returns one result item per input item, in order: the column's
// pressed bits and change flag, with tlast marking the last column of the matrix.
// On that item the sweep change flag, the ghost verdict and the send flag are valid.
// An item accepted into the input register is debounced and written back as it enters
// stage two, and its ghost check over the whole pressed map is registered into the
// output as it leaves. One item is accepted in every cycle unless the output stalls;
// the rate is set by the single debounce pass per column. A stalled output holds its
// item while the two earlier stages still fill, so up to three items are in flight
// before tready falls. Reset clears all histories and pressed bits to released, clears
// the sweep flag and turns de-ghosting on. The configuration write sets de-ghosting;
// the user makes it only while the block is idle, which the block does not enforce.
`include "key_matrix_debounce_deghost_defines.svh"

module key_matrix_debounce_deghost #(
	parameter int ROWS    = kmdd_pkg::ROWS_DEF,
	parameter int COLS    = kmdd_pkg::COLS_DEF,
	parameter int SAMPLES = kmdd_pkg::SAMPLES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// Fields from bit 0: column[3:0], row_pins[11:4], zero fill[15:12].
	input  logic [kmdd_pkg::TDATA_W-1:0] s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// Fields from bit 0: column_out[3:0], pressed_rows[11:4], column_changed[12],
	// sweep_changed[13], ghost_block[14], send_report[15].
	output logic [kmdd_pkg::TDATA_W-1:0] m_tdata,
	output logic                        m_tlast,
	input  logic                        cfg_wr_en,
	input  logic                        cfg_wr_data
);
	import kmdd_pkg::*;

	localparam int PinRows  = (ROWS < PIN_W) ? ROWS : PIN_W;
	localparam int ScanCols = (COLS < (1 << COL_W)) ? COLS : (1 << COL_W);
	localparam int IdxW     = (ScanCols > 1) ? $clog2(ScanCols) : 1;

	typedef logic [PinRows-1:0][SAMPLES-1:0] hist_col_t;

	logic             s1_valid_q;
	logic [COL_W-1:0] col_s1;
	logic [PIN_W-1:0] pins_s1;
	logic             s2_valid_q;
	kmdd_result_t     res_s2;
	logic             out_valid_q;
	kmdd_result_t     out_q;

	hist_col_t                        hist_q [ScanCols];
	logic [ScanCols-1:0][PinRows-1:0] pressed_q;
	logic                             sweep_flag_q;
	logic                             deghost_q;

	logic out_adv, s2_free, s1_adv, in_fire;

	logic             in_range, is_last, col_changed;
	logic [IdxW-1:0]  idx;
	hist_col_t        hist_rd, hist_nx;
	logic [PinRows-1:0] press_rd, press_nx, flip;
	kmdd_result_t     s2_in;

	logic [ScanCols-1:0]         col_multi;
	logic [PinRows-1:0]          row_multi;
	logic [ScanCols*PinRows-1:0] hit;
	logic                        ghost, blk;
	kmdd_result_t                out_in;

	assign out_adv  = s2_valid_q && (!out_valid_q || m_tready);
	assign s2_free  = !s2_valid_q || out_adv;
	assign s1_adv   = s1_valid_q && s2_free;
	assign s_tready = !s1_valid_q || s1_adv;
	assign in_fire  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deghost_q <= 1'b1;
		end else if (cfg_wr_en) begin
			deghost_q <= cfg_wr_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			col_s1  <= s_tdata[COL_W-1:0];
			pins_s1 <= s_tdata[COL_W+PIN_W-1:COL_W];
		end
	end

	// Debounce of the scanned column.
	assign in_range = 32'(col_s1) < COLS;
	assign is_last  = in_range && (32'(col_s1) == COLS - 1);
	assign idx      = col_s1[IdxW-1:0];
	assign hist_rd  = hist_q[idx];
	assign press_rd = pressed_q[idx];

	for (genvar r = 0; r < PinRows; r++) begin : g_row
		logic               down;
		logic [SAMPLES-1:0] h;
		assign down = ~pins_s1[r];
		if (SAMPLES == 1) begin : g_one
			assign h = down;
		end else begin : g_many
			assign h = {hist_rd[r][SAMPLES-2:0], down};
		end
		assign hist_nx[r]  = h;
		assign flip[r]     = (h != {SAMPLES{press_rd[r]}}) && ((h == '0) || (h == '1));
		assign press_nx[r] = flip[r] ? (h == '1) : press_rd[r];
	end

	assign col_changed = in_range && (|flip);

	always_comb begin
		s2_in                = '0;
		s2_in.column_out     = col_s1;
		s2_in.pressed_rows   = in_range ? PIN_W'(press_nx) : '0;
		s2_in.column_changed = col_changed;
		s2_in.sweep_done     = is_last;
		s2_in.sweep_changed  = is_last && (sweep_flag_q || col_changed);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < ScanCols; c++) begin
				hist_q[c] <= '0;
			end
			pressed_q    <= '0;
			sweep_flag_q <= 1'b0;
		end else if (s1_adv && in_range) begin
			hist_q[idx]    <= hist_nx;
			pressed_q[idx] <= press_nx;
			if (is_last) begin
				sweep_flag_q <= 1'b0;
			end else if (col_changed) begin
				sweep_flag_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s2_free) begin
			s2_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res_s2 <= s2_in;
		end
	end

	// Ghost check over the pressed map, which holds the state after the item in stage two.
	for (genvar c = 0; c < ScanCols; c++) begin : g_colm
		assign col_multi[c] = |(pressed_q[c] & (pressed_q[c] - PinRows'(1)));
	end

	for (genvar r = 0; r < PinRows; r++) begin : g_rowm
		logic [ScanCols-1:0] rv;
		for (genvar c = 0; c < ScanCols; c++) begin : g_bit
			assign rv[c]                 = pressed_q[c][r];
			assign hit[c*PinRows + r]    = pressed_q[c][r] && col_multi[c] && row_multi[r];
		end
		assign row_multi[r] = |(rv & (rv - ScanCols'(1)));
	end

	assign ghost = deghost_q && (|hit);
	assign blk   = res_s2.sweep_done && ghost;

	always_comb begin
		out_in             = res_s2;
		out_in.ghost_block = blk;
		out_in.send_report = res_s2.sweep_done && res_s2.sweep_changed && !blk;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= s2_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv) begin
			out_q <= out_in;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_q.sweep_done;
	assign m_tdata  = {out_q.send_report, out_q.ghost_block, out_q.sweep_changed,
		out_q.column_changed, out_q.pressed_rows, out_q.column_out};

	`KMDD_ASSERT_NOW(a_mid_sweep_quiet, m_tvalid && !out_q.sweep_done, !out_q.sweep_changed && !out_q.ghost_block && !out_q.send_report, "Sweep fields set on a column that is not the last.")
	`KMDD_ASSERT_NOW(a_send_consistent, m_tvalid && out_q.send_report, out_q.sweep_changed && !out_q.ghost_block, "Report sent without a change or while blocked.")
	`KMDD_ASSERT_NOW(a_ghost_needs_enable, m_tvalid && out_q.ghost_block, deghost_q, "Ghost block reported with de-ghosting off.")
	`KMDD_ASSERT_NEXT(a_sweep_flag_cleared, s1_adv && is_last, !sweep_flag_q, "Sweep change flag not cleared after the last column.")
	`KMDD_ASSERT_NEXT(a_map_held_in_stall, s2_valid_q && !out_adv, $stable(pressed_q), "Pressed map changed while the ghost stage was stalled.")

endmodule

// ===== verif/key_matrix_debounce_deghost_check.sv =====
// Scoreboard for the key matrix debounce and ghost detection block.
// Watches both streams and the configuration port, predicts each column report
// and compares it field by field. Depends on kmdd_pkg for geometry and layout.
module key_matrix_debounce_deghost_check
	import kmdd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic [TDATA_W-1:0] m_tdata,
	input  logic               m_tlast,
	input  logic               cfg_wr_en,
	input  logic               cfg_wr_data,
	output int                 error_count,
	output int                 reports_due
);

	localparam int ROWS     = ROWS_DEF;
	localparam int COLS     = COLS_DEF;
	localparam int SAMPLES  = SAMPLES_DEF;
	localparam int PIN_ROWS = (ROWS < PIN_W) ? ROWS : PIN_W;
	localparam int NKEYS    = ROWS * COLS;

	logic [SAMPLES-1:0] key_history [NKEYS];
	logic               key_pressed [NKEYS];
	logic               sweep_dirty;
	logic               deghost_on;
	kmdd_result_t       due_reports [$];

	function automatic logic ghost_in_map();
		int col_hits [COLS] = '{default: 0};
		int row_hits [ROWS] = '{default: 0};
		int total = 0;
		for (int c = 0; c < COLS; c++) begin
			for (int r = 0; r < ROWS; r++) begin
				if (key_pressed[c * ROWS + r]) begin
					col_hits[c]++;
					row_hits[r]++;
					total++;
				end
			end
		end
		if (total <= 2)
			return 1'b0;
		for (int c = 0; c < COLS; c++) begin
			for (int r = 0; r < ROWS; r++) begin
				if (key_pressed[c * ROWS + r] && col_hits[c] > 1 && row_hits[r] > 1)
					return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic kmdd_result_t debounce_column(input logic [COL_W-1:0] col,
			input logic [PIN_W-1:0] pins);
		kmdd_result_t rep;
		logic [SAMPLES-1:0] h;
		int k;
		rep = '0;
		rep.column_out = col;
		if (col < COLS) begin
			for (int r = 0; r < PIN_ROWS; r++) begin
				k = int'(col) * ROWS + r;
				h = {key_history[k][SAMPLES-2:0], ~pins[r]};
				key_history[k] = h;
				if ((h == '1 && !key_pressed[k]) || (h == '0 && key_pressed[k])) begin
					key_pressed[k] = (h == '1);
					rep.column_changed = 1'b1;
				end
				rep.pressed_rows[r] = key_pressed[k];
			end
			if (rep.column_changed)
				sweep_dirty = 1'b1;
			if (col == COLS - 1) begin
				rep.sweep_done = 1'b1;
				rep.sweep_changed = sweep_dirty;
				rep.ghost_block = deghost_on && ghost_in_map();
				rep.send_report = rep.sweep_changed && !rep.ghost_block;
				sweep_dirty = 1'b0;
			end
		end
		return rep;
	endfunction

	function automatic void check_field(input string field, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		kmdd_result_t want;
		if (!arst_n) begin
			for (int k = 0; k < NKEYS; k++) begin
				key_history[k] = '0;
				key_pressed[k] = 1'b0;
			end
			sweep_dirty = 1'b0;
			deghost_on = 1'b1;
			due_reports.delete();
			error_count = 0;
			reports_due = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_reports.size() == 0) begin
					$error("Result item arrived with no prediction waiting.");
					error_count++;
				end else begin
					want = due_reports.pop_front();
					check_field("column_out", int'(want.column_out),
						int'(m_tdata[COL_W-1:0]));
					check_field("pressed_rows", int'(want.pressed_rows),
						int'(m_tdata[COL_W +: PIN_W]));
					check_field("column_changed", int'(want.column_changed),
						int'(m_tdata[12]));
					check_field("sweep_done", int'(want.sweep_done), int'(m_tlast));
					check_field("sweep_changed", int'(want.sweep_changed),
						int'(m_tdata[13]));
					check_field("ghost_block", int'(want.ghost_block), int'(m_tdata[14]));
					check_field("send_report", int'(want.send_report), int'(m_tdata[15]));
				end
			end
			if (s_tvalid && s_tready)
				due_reports.push_back(debounce_column(s_tdata[COL_W-1:0],
					s_tdata[COL_W +: PIN_W]));
			if (cfg_wr_en)
				deghost_on = cfg_wr_data;
			reports_due = due_reports.size();
		end
	end

endmodule

// ===== verif/key_matrix_debounce_deghost_tb.sv =====
// Top of the testbench for the key matrix debounce and ghost detection block.
// Drives directed and random column scans with random stalls on both streams and
// leaves prediction to key_matrix_debounce_deghost_check. Depends on kmdd_pkg.
module key_matrix_debounce_deghost_tb;
	import kmdd_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 600;
	localparam int LONG_HOLD    = 150;
	localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLS_DEF - 1);
	localparam logic [PIN_W-1:0] ALL_UP   = '1;
	localparam logic [PIN_W-1:0] ALL_DOWN = '0;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [TDATA_W-1:0] s_tdata = '0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic               m_tlast;
	logic               cfg_wr_en = 1'b0;
	logic               cfg_wr_data = 1'b0;
	int                 error_count;
	int                 reports_due;
	int                 items_sent = 0;
	int                 items_taken = 0;
	int                 cycle_count = 0;
	logic               send_quiet = 1'b0;
	logic               take_quiet = 1'b0;

	key_matrix_debounce_deghost dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	key_matrix_debounce_deghost_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.error_count(error_count),
		.reports_due(reports_due)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic [PIN_W-1:0] pick_pins();
		case ($urandom_range(0, 7))
			0: return ALL_DOWN;
			1, 2: return ALL_UP;
			default: return PIN_W'(~($urandom & $urandom));
		endcase
	endfunction

	function automatic logic [PIN_W-1:0] bounce(input logic [PIN_W-1:0] pins);
		if ($urandom_range(0, 7) == 0)
			return pins ^ PIN_W'(1 << $urandom_range(0, PIN_W - 1));
		return pins;
	endfunction

	task automatic send_column(input logic [COL_W-1:0] col, input logic [PIN_W-1:0] pins);
		int gap;
		@(negedge clk);
		gap = send_quiet ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(TDATA_W - COL_W - PIN_W){1'b0}}, pins, col};
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	task automatic set_deghost(input logic enable);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (reports_due != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= enable;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// The receiver draws a stall per item and once holds off long enough to fill the block.
	initial begin
		int gap;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (items_taken % 40 == 0)
				take_quiet = ($urandom_range(0, 2) == 0);
			gap = take_quiet ? 0 : $urandom_range(0, 10);
			if (items_taken == 300)
				gap = LONG_HOLD;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			items_taken++;
		end
	end

	initial begin
		logic [COL_W-1:0] cols [4];
		logic [PIN_W-1:0] held [4];
		logic [PIN_W-1:0] last_held;
		int ncols;
		int reps;
		int phase_end;
		int choice;

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		set_deghost(1'b1);

		// An L of three pressed keys is a ghost and blocks the report.
		send_column(LAST_COL, ALL_UP);
		repeat (SAMPLES_DEF) send_column(4'd0, 8'hFC);
		repeat (SAMPLES_DEF) send_column(4'd1, 8'hFE);
		send_column(LAST_COL, ALL_UP);

		// With de-ghosting off the L plus column 3 is not blocked; the sweep flag was cleared.
		set_deghost(1'b0);
		send_column(LAST_COL, ALL_UP);
		repeat (SAMPLES_DEF) send_column(4'd3, ALL_DOWN);
		send_column(4'd2, 8'h7F);
		send_column(4'd2, ALL_UP);
		send_column(LAST_COL, ALL_UP);

		for (int phase = 0; phase < 4; phase++) begin
			set_deghost(phase % 2 == 0);
			phase_end = items_sent + RANDOM_ITEMS / 4;
			while (items_sent < phase_end) begin
				choice = $urandom_range(0, 19);
				send_quiet = ($urandom_range(0, 3) == 0);
				if (choice < 2) begin
					repeat ($urandom_range(1, 8))
						send_column(COL_W'($urandom_range(0, 15)),
							PIN_W'($urandom_range(0, 255)));
				end else if (choice == 2) begin
					repeat (SAMPLES_DEF) begin
						for (int c = 0; c < COLS_DEF; c++)
							send_column(COL_W'(c), ALL_UP);
					end
				end else begin
					ncols = $urandom_range(1, 4);
					for (int i = 0; i < 4; i++) begin
						cols[i] = COL_W'($urandom_range(0, COLS_DEF - 2));
						held[i] = pick_pins();
					end
					last_held = pick_pins();
					reps = $urandom_range(3, 7);
					repeat (reps) begin
						for (int i = 0; i < ncols; i++)
							send_column(cols[i], bounce(held[i]));
						send_column(LAST_COL, bounce(last_held));
					end
				end
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (reports_due != 0) @(negedge clk);
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
